FILE: design/lslg_pkg.sv
// Package for the least-squares loss and gradient block.
// Holds the item structs, request and status codes, the state enum and the saturating add.
// No dependencies.
package lslg_pkg;

  localparam int ACC_W = 48;
  localparam int VAL_W = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    REQ_LOAD_W  = 3'd0,
    REQ_LOAD_M  = 3'd1,
    REQ_FEAT    = 3'd2,
    REQ_END     = 3'd3,
    REQ_START   = 3'd4,
    REQ_RD_GRAD = 3'd5,
    REQ_RD_OBJ  = 3'd6
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIDGE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM     = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_SAT       = 2'd2;

  typedef enum logic [1:0] {
    SH15 = 2'd0,
    SH16 = 2'd1,
    SH17 = 2'd2
  } mul_shift_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_FEAT_MUL,
    S_RDG,
    S_ST_RD,
    S_ST_XX,
    S_ST_XM,
    S_ST_OBJ,
    S_ST_GRD_RD,
    S_ST_GRD_MUL,
    S_END_OBJ,
    S_END_RD,
    S_END_MUL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]               req_type;
    logic [5:0]               elem_index;
    logic signed [VAL_W-1:0]  data_value;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0]  result_value;
    logic [1:0]               status;
  } out_t;

  typedef struct packed {
    logic       go;
    mul_shift_t sh;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } mul_stat_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] v;
    logic                    sat;
  } sat_t;

  function automatic sat_t sat_add(input logic signed [ACC_W+1:0] a,
                                   input logic signed [ACC_W+1:0] b);
    logic signed [ACC_W+2:0] s;
    sat_t r;
    s = {a[ACC_W+1], a} + {b[ACC_W+1], b};
    r.sat = 1'b0;
    if (s > 51'sd140737488355327) begin
      r.v = 48'sh7FFF_FFFF_FFFF;
      r.sat = 1'b1;
    end else if (s < -51'sd140737488355328) begin
      r.v = 48'sh8000_0000_0000;
      r.sat = 1'b1;
    end else begin
      r.v = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/least_squares_loss_gradient.sv
// Top level of the least-squares loss and gradient block: sequencer, stores and registers.
// Uses lslg_pkg and the shared multiplier lslg_mul.
//
// Items arrive on in_valid/in_ready as in_t and each gives exactly one out_t item on
// out_valid/out_ready. Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// the user must write them only while the block is idle (unenforced); cfg_ready is always high.
// One item is handled at a time; in_ready is high only when the block is idle.
// All multiplies except the penalty product rho*neigh share one unit.
// Loads, objective reads and rejected items go straight to S_OUT; a gradient read goes via S_RDG.
// A feature element takes one multiply.
// A start item takes two multiplies per dimension for the dot products, one for the objective
// and one per dimension for the gradient seed.
// A sample end takes one multiply for the objective and one per dimension for the gradient.
// After reset the block sweeps the sample buffer and gradient store to zero, one entry a
// cycle, over all MAX_DIM entries, before in_ready rises.
// A result waits in the output register while out_ready is low, and no new item is taken.
module least_squares_loss_gradient import lslg_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = (DW > 7) ? DW : 7;

  state_t state_r, state_nxt;

  logic             mode_r;
  logic [VAL_W-1:0] lam_r;
  logic [VAL_W-1:0] rho_r;
  logic [7:0]       neigh_r;
  logic [6:0]       dim_r;

  logic [CW-1:0]           i_r, i_nxt;
  in_t                     in_r, in_nxt;
  logic signed [ACC_W-1:0] res_r, res_nxt;
  logic signed [ACC_W-1:0] xx_r, xx_nxt;
  logic signed [ACC_W-1:0] xm_r, xm_nxt;
  logic signed [ACC_W-1:0] obj_r, obj_nxt;
  logic signed [ACC_W-1:0] dot_r, dot_nxt;
  logic                    flag_r, flag_nxt;
  logic                    bad_r, bad_nxt;
  logic signed [ACC_W-1:0] result_r, result_nxt;

  logic [VAL_W-1:0] weight_mem [MAX_DIM];
  logic [VAL_W-1:0] msg_mem [MAX_DIM];
  logic [VAL_W-1:0] buf_mem [MAX_DIM];
  logic [ACC_W-1:0] grad_mem [MAX_DIM];
  logic [VAL_W-1:0] w_q, m_q, b_q;
  logic [ACC_W-1:0] g_q;

  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    in_addr;
  logic             w_we, m_we, b_we, g_we;
  logic [AW-1:0]    w_wa, b_wa, g_wa;
  logic [VAL_W-1:0] b_wd;
  logic [ACC_W-1:0] g_wd;

  logic [CW-1:0]           eff_d;
  logic [CW-1:0]           dim_ext;
  logic                    accept;
  logic                    idx_bad;
  logic                    indexed;
  logic                    i_in_use;
  logic                    i_last;
  logic [39:0]             rn;
  mul_req_t                mreq;
  mul_stat_t               mstat;
  logic signed [ACC_W-1:0] mul_a, mul_b, prod;
  logic signed [ACC_W-1:0] w_ext, m_ext, b_ext, val_ext;
  sat_t                    sa;

  assign dim_ext = CW'(dim_r);
  assign eff_d = (dim_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : dim_ext;
  assign accept = in_valid && in_ready;
  assign in_addr = AW'(in_data.elem_index);
  assign indexed = in_data.req_type == REQ_LOAD_W || in_data.req_type == REQ_LOAD_M ||
                   in_data.req_type == REQ_FEAT || in_data.req_type == REQ_RD_GRAD;
  assign idx_bad = indexed && (CW'(in_data.elem_index) >= eff_d);
  assign i_in_use = i_r < eff_d;
  assign i_last = i_r == CW'(MAX_DIM - 1);
  assign rn = rho_r * neigh_r;
  assign rd_addr = (state_r == S_IDLE) ? in_addr : i_r[AW-1:0];

  assign w_ext = ACC_W'(signed'(w_q));
  assign m_ext = ACC_W'(signed'(m_q));
  assign b_ext = ACC_W'(signed'(b_q));
  assign val_ext = ACC_W'(in_r.data_value);

  assign cfg_ready = 1'b1;
  assign in_ready = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_data.result_value = result_r;
  assign out_data.status = bad_r ? ST_BAD_INDEX : (flag_r ? ST_SAT : ST_OK);

  lslg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .stat  (mstat),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      lam_r <= '0;
      rho_r <= '0;
      neigh_r <= '0;
      dim_r <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:    mode_r <= cfg_data[0];
        CFG_RIDGE:   lam_r <= cfg_data;
        CFG_PENALTY: rho_r <= cfg_data;
        CFG_NEIGH:   neigh_r <= cfg_data[7:0];
        CFG_DIM:     dim_r <= cfg_data[6:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) weight_mem[w_wa] <= in_r.data_value;
    if (m_we) msg_mem[w_wa] <= in_r.data_value;
    if (b_we) buf_mem[b_wa] <= b_wd;
    if (g_we) grad_mem[g_wa] <= g_wd;
    w_q <= weight_mem[rd_addr];
    m_q <= msg_mem[rd_addr];
    b_q <= buf_mem[rd_addr];
    g_q <= grad_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:        if (i_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (idx_bad) begin
            state_nxt = S_OUT;
          end else begin
            unique case (in_data.req_type)
              REQ_FEAT:    state_nxt = S_FEAT_MUL;
              REQ_END:     state_nxt = S_END_OBJ;
              REQ_START:   state_nxt = (eff_d == '0) ? S_ST_OBJ : S_ST_RD;
              REQ_RD_GRAD: state_nxt = S_RDG;
              default:     state_nxt = S_OUT;
            endcase
          end
        end
      end
      S_FEAT_MUL:   if (mstat.done) state_nxt = S_OUT;
      S_RDG:        state_nxt = S_OUT;
      S_ST_RD:      state_nxt = S_ST_XX;
      S_ST_XX:      if (mstat.done) state_nxt = S_ST_XM;
      S_ST_XM: begin
        if (mstat.done) state_nxt = (CW'(i_r + 1'b1) == eff_d) ? S_ST_OBJ : S_ST_RD;
      end
      S_ST_OBJ:     if (mstat.done) state_nxt = S_ST_GRD_RD;
      S_ST_GRD_RD: begin
        if (i_in_use) state_nxt = S_ST_GRD_MUL;
        else if (i_last) state_nxt = S_OUT;
      end
      S_ST_GRD_MUL: if (mstat.done) state_nxt = i_last ? S_OUT : S_ST_GRD_RD;
      S_END_OBJ:    if (mstat.done) state_nxt = S_END_RD;
      S_END_RD: begin
        if (i_in_use) state_nxt = S_END_MUL;
        else if (i_last) state_nxt = S_OUT;
      end
      S_END_MUL:    if (mstat.done) state_nxt = i_last ? S_OUT : S_END_RD;
      S_OUT:        if (out_ready) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    i_nxt = i_r;
    in_nxt = in_r;
    res_nxt = res_r;
    xx_nxt = xx_r;
    xm_nxt = xm_r;
    obj_nxt = obj_r;
    dot_nxt = dot_r;
    flag_nxt = flag_r;
    bad_nxt = bad_r;
    result_nxt = result_r;
    w_we = 1'b0;
    m_we = 1'b0;
    b_we = 1'b0;
    g_we = 1'b0;
    w_wa = AW'(in_r.elem_index);
    b_wa = i_r[AW-1:0];
    g_wa = i_r[AW-1:0];
    b_wd = '0;
    g_wd = '0;
    mreq.go = 1'b0;
    mreq.sh = SH16;
    mul_a = w_ext;
    mul_b = w_ext;
    sa = sat_add('0, '0);
    unique case (state_r)
      S_CLR: begin
        b_we = 1'b1;
        g_we = 1'b1;
        i_nxt = CW'(i_r + 1'b1);
      end
      S_IDLE: begin
        i_nxt = '0;
        if (accept) begin
          in_nxt = in_data;
          bad_nxt = idx_bad;
          result_nxt = '0;
          if (!idx_bad) begin
            unique case (in_data.req_type)
              REQ_FEAT: begin
                b_we = 1'b1;
                b_wa = in_addr;
                b_wd = in_data.data_value;
              end
              REQ_END: begin
                sa = sat_add(ACC_W'(in_data.data_value) + 50'sd0, -(dot_r + 50'sd0));
                res_nxt = sa.v;
                flag_nxt = flag_r | sa.sat;
              end
              REQ_START: begin
                flag_nxt = 1'b0;
                dot_nxt = '0;
                xx_nxt = '0;
                xm_nxt = '0;
              end
              REQ_RD_OBJ: result_nxt = obj_r;
              default: ;
            endcase
          end
        end
      end
      S_FEAT_MUL: begin
        mreq.go = !mstat.busy && !mstat.done;
        mul_a = w_ext;
        mul_b = val_ext;
        if (mstat.done) begin
          sa = sat_add(dot_r + 50'sd0, prod + 50'sd0);
          dot_nxt = sa.v;
          flag_nxt = flag_r | mstat.sat | sa.sat;
        end
      end
      S_RDG: result_nxt = g_q;
      S_ST_RD: ;
      S_ST_XX: begin
        mreq.go = !mstat.busy && !mstat.done;
        if (mstat.done) begin
          sa = sat_add(xx_r + 50'sd0, prod + 50'sd0);
          xx_nxt = sa.v;
          flag_nxt = flag_r | mstat.sat | sa.sat;
        end
      end
      S_ST_XM: begin
        mreq.go = !mstat.busy && !mstat.done;
        mul_b = m_ext;
        if (mstat.done) begin
          sa = sat_add(xm_r + 50'sd0, prod + 50'sd0);
          xm_nxt = sa.v;
          flag_nxt = flag_r | mstat.sat | sa.sat;
          i_nxt = CW'(i_r + 1'b1);
        end
      end
      S_ST_OBJ: begin
        mreq.go = !mstat.busy && !mstat.done;
        mul_b = xx_r;
        if (mode_r) begin
          mul_a = ACC_W'(rn);
        end else begin
          mul_a = ACC_W'(lam_r);
          mreq.sh = SH17;
        end
        if (mstat.done) begin
          i_nxt = '0;
          if (mode_r) begin
            sa = sat_add(prod + 50'sd0, xm_r + 50'sd0);
            obj_nxt = sa.v;
            flag_nxt = flag_r | mstat.sat | sa.sat;
          end else begin
            obj_nxt = prod;
            flag_nxt = flag_r | mstat.sat;
          end
        end
      end
      S_ST_GRD_RD: begin
        b_we = 1'b1;
        if (!i_in_use) begin
          g_we = 1'b1;
          i_nxt = CW'(i_r + 1'b1);
        end
      end
      S_ST_GRD_MUL: begin
        mreq.go = !mstat.busy && !mstat.done;
        if (mode_r) begin
          mul_a = ACC_W'(rn);
          mreq.sh = SH15;
        end else begin
          mul_a = ACC_W'(lam_r);
        end
        if (mstat.done) begin
          g_we = 1'b1;
          i_nxt = CW'(i_r + 1'b1);
          if (mode_r) begin
            sa = sat_add(prod + 50'sd0, m_ext + 50'sd0);
            g_wd = sa.v;
            flag_nxt = flag_r | mstat.sat | sa.sat;
          end else begin
            g_wd = prod;
            flag_nxt = flag_r | mstat.sat;
          end
        end
      end
      S_END_OBJ: begin
        mreq.go = !mstat.busy && !mstat.done;
        mul_a = res_r;
        mul_b = res_r;
        if (mstat.done) begin
          sa = sat_add(obj_r + 50'sd0, prod + 50'sd0);
          obj_nxt = sa.v;
          flag_nxt = flag_r | mstat.sat | sa.sat;
          i_nxt = '0;
        end
      end
      S_END_RD: begin
        if (!i_in_use) begin
          b_we = 1'b1;
          i_nxt = CW'(i_r + 1'b1);
          if (i_last) dot_nxt = '0;
        end
      end
      S_END_MUL: begin
        mreq.go = !mstat.busy && !mstat.done;
        mul_a = res_r;
        mul_b = b_ext;
        mreq.sh = SH15;
        if (mstat.done) begin
          sa = sat_add(signed'(g_q) + 50'sd0, -(prod + 50'sd0));
          g_we = 1'b1;
          g_wd = sa.v;
          b_we = 1'b1;
          flag_nxt = flag_r | mstat.sat | sa.sat;
          i_nxt = CW'(i_r + 1'b1);
          if (i_last) dot_nxt = '0;
        end
      end
      S_OUT: begin
        if (!bad_r && in_r.req_type == REQ_LOAD_W && out_ready) w_we = 1'b1;
        if (!bad_r && in_r.req_type == REQ_LOAD_M && out_ready) m_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      i_r <= '0;
      obj_r <= '0;
      dot_r <= '0;
      flag_r <= 1'b0;
      bad_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      obj_r <= obj_nxt;
      dot_r <= dot_nxt;
      flag_r <= flag_nxt;
      bad_r <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
    res_r <= res_nxt;
    xx_r <= xx_nxt;
    xm_r <= xm_nxt;
    result_r <= result_nxt;
  end

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");
  a_obj_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.req_type == REQ_RD_OBJ |=> out_valid && result_r == $past(obj_r))
    else $error("objective read did not return the objective");
  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mstat.done |-> state_r == S_FEAT_MUL || state_r == S_ST_XX || state_r == S_ST_XM ||
                   state_r == S_ST_OBJ || state_r == S_ST_GRD_MUL ||
                   state_r == S_END_OBJ || state_r == S_END_MUL)
    else $error("multiplier finished outside a multiply step");
`endif

endmodule

FILE: design/lslg_mul.sv
// Shared fixed-point multiplier: 48x48 signed product built from 24x24 partial products.
// The magnitude is shifted right by 15, 16 or 17 and saturated to 48 bits. Uses lslg_pkg.
module lslg_mul import lslg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mul_req_t                req,
  input  logic signed [ACC_W-1:0] op_a,
  input  logic signed [ACC_W-1:0] op_b,
  output mul_stat_t               stat,
  output logic signed [ACC_W-1:0] prod
);

  logic             running_r;
  logic             done_r;
  logic [2:0]       cnt_r;
  logic             neg_r;
  mul_shift_t       sh_r;
  logic [ACC_W-1:0] ma_r;
  logic [ACC_W-1:0] mb_r;
  logic [95:0]      acc_r;
  logic signed [ACC_W-1:0] prod_r;
  logic             sat_r;

  logic [23:0]      x;
  logic [23:0]      y;
  logic [47:0]      pp;
  logic [95:0]      ppw;
  logic [80:0]      shifted;
  logic [80:0]      lim;
  logic             over;
  logic [ACC_W-1:0] mag;

  assign x = (cnt_r == 3'd0 || cnt_r == 3'd1) ? ma_r[23:0] : ma_r[47:24];
  assign y = (cnt_r == 3'd0 || cnt_r == 3'd2) ? mb_r[23:0] : mb_r[47:24];
  assign pp = x * y;

  always_comb begin
    unique case (cnt_r)
      3'd0:    ppw = 96'(pp);
      3'd1,
      3'd2:    ppw = 96'(pp) << 24;
      default: ppw = 96'(pp) << 48;
    endcase
  end

  always_comb begin
    unique case (sh_r)
      SH15:    shifted = acc_r[95:15];
      SH16:    shifted = 81'(acc_r >> 16);
      SH17:    shifted = 81'(acc_r >> 17);
      default: shifted = 81'(acc_r >> 16);
    endcase
    lim = neg_r ? 81'h8000_0000_0000 : 81'h7FFF_FFFF_FFFF;
    over = shifted > lim;
    mag = over ? lim[ACC_W-1:0] : shifted[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.go && !running_r && !done_r) begin
        running_r <= 1'b1;
        cnt_r <= 3'd0;
      end else if (running_r) begin
        if (cnt_r == 3'd4) begin
          running_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && !running_r && !done_r) begin
      neg_r <= op_a[ACC_W-1] ^ op_b[ACC_W-1];
      ma_r <= op_a[ACC_W-1] ? ACC_W'(-op_a) : op_a;
      mb_r <= op_b[ACC_W-1] ? ACC_W'(-op_b) : op_b;
      sh_r <= req.sh;
      acc_r <= '0;
    end else if (running_r) begin
      if (cnt_r == 3'd4) begin
        prod_r <= neg_r ? ACC_W'(-mag) : mag;
        sat_r <= over;
      end else begin
        acc_r <= acc_r + ppw;
      end
    end
  end

  assign stat.busy = running_r;
  assign stat.done = done_r;
  assign stat.sat = sat_r;
  assign prod = prod_r;

`ifndef ASSERT_OFF
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> $past(running_r) && $past(cnt_r) == 3'd4)
    else $error("multiplier done without a finished run");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(running_r && done_r))
    else $error("multiplier running and done together");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> cnt_r <= 3'd4)
    else $error("multiplier step count out of range");
`endif

endmodule
